// File: rtl/msp_pkg.sv
// ----------------------------------------------------------------------------
// msp_pkg
// Shared types and constants of the MIDI byte stream parser.
// ----------------------------------------------------------------------------
package msp_pkg;

  localparam int unsigned SysexBytes = 64;
  localparam int unsigned LenW       = $clog2(SysexBytes + 1);
  localparam int unsigned AddrW      = $clog2(SysexBytes);

  localparam logic [7:0] ByteRtFirst = 8'hF8;
  localparam logic [7:0] ByteReset   = 8'hFF;
  localparam logic [7:0] ByteSxStart = 8'hF0;
  localparam logic [7:0] ByteSxEnd   = 8'hF7;
  localparam logic [3:0] ClsProgram  = 4'hC;
  localparam logic [3:0] ClsPressure = 4'hD;

  localparam logic [1:0] KindChannel  = 2'd0;
  localparam logic [1:0] KindRealtime = 2'd1;
  localparam logic [1:0] KindSysex    = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RD   = 3'b010,
    ST_LOAD = 3'b100
  } state_e;

  typedef struct packed {
    logic take;
    logic rd;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic dump_req;
    logic rd_last;
  } stat_t;

endpackage

// File: rtl/msp_ctrl.sv
// ----------------------------------------------------------------------------
// msp_ctrl
// Sequencer: takes requests and walks the SysEx buffer on a run's end.
// ----------------------------------------------------------------------------
module msp_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  msp_pkg::stat_t  stat_i,
  output msp_pkg::cmd_t   cmd_o
);
  import msp_pkg::*;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = stat_i.out_free;
        cmd_o.take = in_valid_i & stat_i.out_free;
        if (cmd_o.take && stat_i.dump_req) begin
          state_d = ST_RD;
        end
      end
      ST_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = ST_LOAD;
      end
      ST_LOAD: begin
        if (stat_i.out_free) begin
          cmd_o.load = 1'b1;
          state_d    = stat_i.rd_last ? ST_IDLE : ST_RD;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: rtl/msp_dpath.sv
// ----------------------------------------------------------------------------
// msp_dpath
// Parser state, SysEx buffer memory and result register.
// ----------------------------------------------------------------------------
module msp_dpath (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [7:0]      rx_byte_i,
  input  msp_pkg::cmd_t   cmd_i,
  output msp_pkg::stat_t  stat_o,
  input  logic            out_ready_i,
  output logic            out_valid_o,
  output logic [1:0]      result_kind_o,
  output logic [7:0]      byte_a_o,
  output logic [6:0]      byte_b_o,
  output logic [6:0]      byte_c_o,
  output logic            last_of_run_o
);
  import msp_pkg::*;

  logic [7:0]      run_status_q, run_status_d;
  logic            data_count_q, data_count_d;
  logic [6:0]      first_data_q, first_data_d;
  logic            sx_active_q, sx_active_d;
  logic [LenW-1:0] sx_len_q, sx_len_d;
  logic [AddrW-1:0] rd_idx_q, rd_idx_d;
  logic [7:0]      rd_data_q;
  logic [7:0]      sx_mem [SysexBytes];

  logic            mem_we;
  logic [AddrW-1:0] mem_waddr;
  logic [7:0]      mem_wdata;

  logic            out_valid_q;
  logic [1:0]      kind_q;
  logic [7:0]      a_q;
  logic [6:0]      b_q, c_q;
  logic            last_q;

  logic            emit;
  logic [1:0]      e_kind;
  logic [7:0]      e_a;
  logic [6:0]      e_b, e_c;
  logic            e_last;

  logic            room, is_rt, one_data, out_free;

  assign room     = sx_len_q < LenW'(SysexBytes);
  assign is_rt    = (rx_byte_i >= ByteRtFirst) && (rx_byte_i != ByteReset);
  assign one_data = (run_status_q[7:4] == ClsProgram) || (run_status_q[7:4] == ClsPressure);
  assign out_free = !out_valid_q || out_ready_i;

  assign stat_o.out_free = out_free;
  assign stat_o.dump_req = sx_active_q && (rx_byte_i == ByteSxEnd) && room;
  assign stat_o.rd_last  = ({1'b0, rd_idx_q} == (sx_len_q - LenW'(1)));

  always_comb begin
    run_status_d = run_status_q;
    data_count_d = data_count_q;
    first_data_d = first_data_q;
    sx_active_d  = sx_active_q;
    sx_len_d     = sx_len_q;
    rd_idx_d     = rd_idx_q;
    mem_we       = 1'b0;
    mem_waddr    = sx_len_q[AddrW-1:0];
    mem_wdata    = rx_byte_i;
    emit         = 1'b0;
    e_kind       = KindChannel;
    e_a          = run_status_q;
    e_b          = '0;
    e_c          = '0;
    e_last       = 1'b1;
    if (cmd_i.take) begin
      rd_idx_d = '0;
      if (is_rt) begin
        emit   = 1'b1;
        e_kind = KindRealtime;
        e_a    = rx_byte_i;
      end else if (rx_byte_i == ByteSxStart) begin
        run_status_d = '0;
        data_count_d = 1'b0;
        sx_active_d  = 1'b1;
        mem_we       = 1'b1;
        mem_waddr    = '0;
        sx_len_d     = LenW'(1);
      end else if (sx_active_q && rx_byte_i == ByteSxEnd) begin
        sx_active_d = 1'b0;
        if (room) begin
          mem_we   = 1'b1;
          sx_len_d = sx_len_q + LenW'(1);
        end
      end else if (sx_active_q && !rx_byte_i[7]) begin
        if (room) begin
          mem_we   = 1'b1;
          sx_len_d = sx_len_q + LenW'(1);
        end
      end else begin
        if (sx_active_q) begin
          sx_active_d = 1'b0;
          sx_len_d    = '0;
        end
        if (rx_byte_i == ByteSxEnd) begin
          // stray end of SysEx: ignored
        end else if (rx_byte_i[7]) begin
          run_status_d = rx_byte_i;
          data_count_d = 1'b0;
        end else if (run_status_q != '0) begin
          if (one_data) begin
            emit         = 1'b1;
            e_b          = rx_byte_i[6:0];
            data_count_d = 1'b0;
          end else if (!data_count_q) begin
            first_data_d = rx_byte_i[6:0];
            data_count_d = 1'b1;
          end else begin
            emit         = 1'b1;
            e_b          = first_data_q;
            e_c          = rx_byte_i[6:0];
            data_count_d = 1'b0;
          end
        end
      end
    end else if (cmd_i.load) begin
      emit     = 1'b1;
      e_kind   = KindSysex;
      e_a      = rd_data_q;
      e_last   = stat_o.rd_last;
      rd_idx_d = rd_idx_q + AddrW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      sx_mem[mem_waddr] <= mem_wdata;
    end
    if (cmd_i.rd) begin
      rd_data_q <= sx_mem[rd_idx_q];
    end
    if (emit) begin
      kind_q <= e_kind;
      a_q    <= e_a;
      b_q    <= e_b;
      c_q    <= e_c;
      last_q <= e_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_status_q <= '0;
      data_count_q <= 1'b0;
      first_data_q <= '0;
      sx_active_q  <= 1'b0;
      sx_len_q     <= '0;
      rd_idx_q     <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      run_status_q <= run_status_d;
      data_count_q <= data_count_d;
      first_data_q <= first_data_d;
      sx_active_q  <= sx_active_d;
      sx_len_q     <= sx_len_d;
      rd_idx_q     <= rd_idx_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign result_kind_o = kind_q;
  assign byte_a_o      = a_q;
  assign byte_b_o      = b_q;
  assign byte_c_o      = c_q;
  assign last_of_run_o = last_q;

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sx_len_q <= LenW'(SysexBytes))
    else $error("SysEx length beyond buffer");

  a_rd_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rd |-> ({1'b0, rd_idx_q} < sx_len_q))
    else $error("buffer read past stored bytes");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> out_free)
    else $error("pending result overwritten");

  a_take_load_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.take && (cmd_i.load || cmd_i.rd)))
    else $error("request taken during buffer dump");

endmodule

// File: rtl/midi_stream_parser.sv
// ----------------------------------------------------------------------------
// midi_stream_parser
// MIDI byte stream parser with running status and SysEx buffering.
// ----------------------------------------------------------------------------
//  channel  dir  tdata                            tuser        tlast
//  s_axis   in   [7:0] rx_byte                    -            -
//  m_axis   out  [7:0] a, [14:8] b, [21:15] c     result_kind  last_of_run
//
//  A new request is taken each cycle while the output is free and no SysEx dump
//  runs; a result is registered and shown the cycle after. A SysEx end starts a dump of
//  up to 64 buffered bytes, each by a registered buffer read, then a load of the result register.
//  Output stalls hold the result register and pause intake or the dump.
//  Asynchronous reset; the buffer needs no clearing pass.
// ----------------------------------------------------------------------------
module midi_stream_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] rx_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // [7:0] byte_a, [14:8] byte_b, [21:15] byte_c
  output logic [1:0]  m_axis_tuser_o,   // [1:0] result_kind
  output logic        m_axis_tlast_o    // last_of_run
);
  import msp_pkg::*;

  cmd_t       cmd;
  stat_t      stat;
  logic [7:0] byte_a;
  logic [6:0] byte_b, byte_c;

  msp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  msp_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .rx_byte_i     (s_axis_tdata_i),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .out_ready_i   (m_axis_tready_i),
    .out_valid_o   (m_axis_tvalid_o),
    .result_kind_o (m_axis_tuser_o),
    .byte_a_o      (byte_a),
    .byte_b_o      (byte_b),
    .byte_c_o      (byte_c),
    .last_of_run_o (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {2'b00, byte_c, byte_b, byte_a};

endmodule

// File: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for midi_stream_parser. Bytes go in over the input
// stream; a local parser with running status and SysEx buffering predicts
// every result, and each output request is checked field by field against
// the oldest prediction. Covers directed corner cases, SysEx size limits,
// constrained-by-hand random traffic under several idle/stall mixes, and a
// long output hold that backs the block up into its input.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import msp_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned LongHold   = 400;
  localparam int unsigned DrainWait  = 300;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] a;
    logic [6:0] b;
    logic [6:0] c;
    logic       last;
  } midi_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  midi_result_t pending_msgs[$];
  int unsigned  error_count = 0;
  int unsigned  cycle_count = 0;
  int unsigned  bytes_sent = 0;
  int unsigned  send_idle_pct = 0;
  int unsigned  recv_stall_pct = 0;
  int unsigned  hold_left = 0;
  bit           hold_req = 1'b0;

  // parser state
  logic [7:0]  run_status = '0;
  logic        have_first = 1'b0;
  logic [6:0]  first_data = '0;
  logic        sx_open = 1'b0;
  int unsigned sx_fill = 0;
  logic [7:0]  sysex_buf[SysexBytes];

  midi_stream_parser uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tuser_o  (m_axis_tuser),
    .m_axis_tlast_o  (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("tb: errors");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_left = LongHold;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic report_error(input string msg);
    $display("%0t: mismatch: %s", $realtime, msg);
    error_count++;
  endtask

  function automatic midi_result_t make_result(input logic [1:0] kind, input logic [7:0] a,
                                               input logic [6:0] b, input logic [6:0] c,
                                               input logic last);
    midi_result_t r;
    r.kind = kind;
    r.a    = a;
    r.b    = b;
    r.c    = c;
    r.last = last;
    return r;
  endfunction

  function automatic void parse_midi_byte(input logic [7:0] rx);
    if (rx >= ByteRtFirst && rx != ByteReset) begin
      pending_msgs.push_back(make_result(KindRealtime, rx, '0, '0, 1'b1));
      return;
    end
    if (rx == ByteSxStart) begin
      run_status = '0;
      have_first = 1'b0;
      sx_open = 1'b1;
      sysex_buf[0] = ByteSxStart;
      sx_fill = 1;
      return;
    end
    if (sx_open) begin
      if (rx == ByteSxEnd) begin
        sx_open = 1'b0;
        // full store: no room for the end byte, message dropped
        if (sx_fill >= SysexBytes) return;
        sysex_buf[sx_fill] = ByteSxEnd;
        sx_fill++;
        for (int k = 0; k < sx_fill; k++)
          pending_msgs.push_back(make_result(KindSysex, sysex_buf[k], '0, '0,
                                             k == sx_fill - 1));
        return;
      end
      if (rx[7]) begin
        sx_open = 1'b0;
        sx_fill = 0;
      end else begin
        if (sx_fill < SysexBytes) begin
          sysex_buf[sx_fill] = rx;
          sx_fill++;
        end
        return;
      end
    end
    if (rx == ByteSxEnd) return;
    if (rx[7]) begin
      run_status = rx;
      have_first = 1'b0;
      return;
    end
    if (run_status == '0) return;
    if (run_status[7:4] == ClsProgram || run_status[7:4] == ClsPressure) begin
      pending_msgs.push_back(make_result(KindChannel, run_status, rx[6:0], '0, 1'b1));
      have_first = 1'b0;
      return;
    end
    if (!have_first) begin
      first_data = rx[6:0];
      have_first = 1'b1;
      return;
    end
    pending_msgs.push_back(make_result(KindChannel, run_status, first_data, rx[6:0], 1'b1));
    have_first = 1'b0;
  endfunction

  always @(posedge clk_i) begin : check_results
    midi_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_msgs.size() == 0) begin
        report_error($sformatf("unexpected result data %06h user %0d last %0b",
                               m_axis_tdata, m_axis_tuser, m_axis_tlast));
      end else begin
        want = pending_msgs.pop_front();
        if (m_axis_tuser !== want.kind)
          report_error($sformatf("result_kind got %0d exp %0d", m_axis_tuser, want.kind));
        if (m_axis_tdata[7:0] !== want.a)
          report_error($sformatf("byte_a got %02h exp %02h", m_axis_tdata[7:0], want.a));
        if (m_axis_tdata[14:8] !== want.b)
          report_error($sformatf("byte_b got %02h exp %02h", m_axis_tdata[14:8], want.b));
        if (m_axis_tdata[21:15] !== want.c)
          report_error($sformatf("byte_c got %02h exp %02h", m_axis_tdata[21:15], want.c));
        if (m_axis_tlast !== want.last)
          report_error($sformatf("last_of_run got %0b exp %0b", m_axis_tlast, want.last));
      end
    end
  end

  // called right after a rising edge; returns at the edge that took the request
  task automatic send_byte(input logic [7:0] rx);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= rx;
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    parse_midi_byte(rx);
    bytes_sent++;
  endtask

  task automatic test_directed();
    logic [7:0] seq[$];
    seq = '{8'h00, 8'h7F,                          // data before any status
            8'hF8,
            8'hFF, 8'h7F, 8'h00,                   // FF is a status here
            8'h90, 8'h01, 8'h02, 8'h11,            // partial under running status
            8'hC5, 8'h7F, 8'hD0, 8'h00, 8'h7F,     // one data byte classes
            8'hF7,                                 // stray end
            8'hF0, 8'h01, 8'hFE, 8'h02, 8'hF7,     // real-time inside SysEx
            8'hF0, 8'h05, 8'h90, 8'h06, 8'h07};    // status aborts SysEx
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  task automatic test_sysex_limits();
    // store exactly full, one byte over
    int unsigned lens[2] = '{SysexBytes - 2, SysexBytes - 1};
    foreach (lens[i]) begin
      send_byte(ByteSxStart);
      repeat (lens[i]) send_byte(8'($urandom_range(127)));
      send_byte(ByteSxEnd);
    end
  endtask

  task automatic test_random(input int unsigned count);
    int unsigned start;
    int unsigned pick;
    int unsigned len;
    logic [7:0]  status;
    start = bytes_sent;
    status = 8'h90;
    while (bytes_sent - start < count) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        if ($urandom_range(99) < 65) begin
          status = 8'h80 + 8'($urandom_range(111));
          send_byte(status);
        end
        if ($urandom_range(99) < 10) send_byte(ByteRtFirst + 8'($urandom_range(6)));
        send_byte(8'($urandom_range(127)));
        if (status[7:4] != ClsProgram && status[7:4] != ClsPressure)
          send_byte(8'($urandom_range(127)));
      end else if (pick < 55) begin
        send_byte(ByteRtFirst + 8'($urandom_range(6)));
      end else if (pick < 72) begin
        len = $urandom_range(8);
        send_byte(ByteSxStart);
        repeat (len) begin
          if ($urandom_range(99) < 8) send_byte(ByteRtFirst + 8'($urandom_range(6)));
          send_byte(8'($urandom_range(127)));
        end
        if ($urandom_range(99) < 15) send_byte(8'h80 + 8'($urandom_range(111)));
        else send_byte(ByteSxEnd);
      end else if (pick < 82) begin
        status = ($urandom_range(6) == 0) ? ByteReset : 8'hF0 + 8'($urandom_range(6, 1));
        send_byte(status);
        send_byte(8'($urandom_range(127)));
        send_byte(8'($urandom_range(127)));
      end else begin
        send_byte(8'($urandom_range(255)));
      end
    end
  endtask

  task automatic test_backpressure();
    hold_req = 1'b1;
    repeat (4) send_byte(ByteRtFirst + 8'($urandom_range(6)));
    send_byte(ByteSxStart);
    repeat (3) send_byte(8'($urandom_range(127)));
    send_byte(ByteSxEnd);
    send_byte(8'hB0 + 8'($urandom_range(15)));
    send_byte(8'($urandom_range(127)));
    send_byte(8'($urandom_range(127)));
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_directed();
    test_sysex_limits();
    test_random(5);

    send_idle_pct = 48;
    test_random(5);

    send_idle_pct = 0;
    recv_stall_pct = 48;
    test_random(5);
    test_backpressure();

    send_idle_pct = 38;
    recv_stall_pct = 38;
    test_random(5);

    s_axis_tvalid <= 1'b0;
    while (pending_msgs.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);

    if (error_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
